>>> rtl/rgba_gray_box_downsample_macros.svh
// Assertion macros shared by the gray box downsampler modules.
`ifndef RGBA_GRAY_BOX_DOWNSAMPLE_MACROS_SVH
`define RGBA_GRAY_BOX_DOWNSAMPLE_MACROS_SVH

// Plain property sampled on the block clock, off during reset.
`define RGDS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Same-cycle implication.
`define RGDS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RGDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/rgds_pkg.sv
// Shared types, register codes and constants of the gray box downsampler.
package rgds_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DOWN_FACTOR  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 2'd3;

  // Row count limit and factor register width (factor up to 16)
  localparam int HEIGHT_W     = 13;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int FACTOR_W     = 5;

  // Luma weights
  localparam logic [15:0] LUMA_R = 16'd77;
  localparam logic [15:0] LUMA_G = 16'd150;
  localparam logic [15:0] LUMA_B = 16'd29;

  // Box average by reciprocal: q = (sum * ceil(2^24 / f^2)) >> 24, exact for sums < 2^16
  localparam int RECIP_W     = 25;
  localparam int RECIP_SHIFT = 24;

  typedef struct packed {
    logic [7:0] chan_red;
    logic [7:0] chan_green;
    logic [7:0] chan_blue;
  } pix_t;

  typedef struct packed {
    logic [7:0] out_gray;
    logic       row_end;
    logic       frame_end;
  } res_t;

  // Per-beat command from the controller to the datapath
  typedef struct packed {
    logic                load;
    logic                pass;
    logic                rgba;
    logic                active;
    logic                col_first;
    logic                col_last;
    logic                row_first;
    logic                emit;
    logic                row_end;
    logic                frame_end;
    logic [FACTOR_W-1:0] factor;
  } cmd_t;

  // Datapath status back to the controller
  typedef struct packed {
    logic advance;
  } stat_t;

  // Reciprocal of the box area, one entry per factor
  function automatic logic [RECIP_W-1:0] recip_of(input logic [FACTOR_W-1:0] f);
    logic [RECIP_W-1:0] r;
    case (f)
      5'd2:    r = 25'd4194304;
      5'd3:    r = 25'd1864136;
      5'd4:    r = 25'd1048576;
      5'd5:    r = 25'd671089;
      5'd6:    r = 25'd466034;
      5'd7:    r = 25'd342393;
      5'd8:    r = 25'd262144;
      5'd9:    r = 25'd207127;
      5'd10:   r = 25'd167773;
      5'd11:   r = 25'd138655;
      5'd12:   r = 25'd116509;
      5'd13:   r = 25'd99274;
      5'd14:   r = 25'd85599;
      5'd15:   r = 25'd74566;
      5'd16:   r = 25'd65536;
      default: r = 25'd16777216;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/rgba_gray_box_downsample.sv
// Top level of the RGBA-to-gray box-average downsampler.
// Usage:
//   Source pixels enter in raster order on the in channel (valid/stall), one
//   beat per pixel; gray mode uses chan_red, RGBA mode converts to luma.
//   Results leave on the out channel (valid/stall): one gray value per
//   factor-by-factor box, or one per pixel when the factor is 0 or 1, with
//   row_end and frame_end flags. Partial boxes at the right and bottom edges
//   are consumed without a result.
//   Configuration is written through cfg_we_i/cfg_index_i/cfg_data_i while
//   no pixel is in flight; every write restarts the frame.
// Timing:
//   One pixel per cycle sustained while the output is not stalled. The beat
//   completing a box is captured in stage 1, then luma into stage 2, column
//   sum update into stage 3 and reciprocal multiply into the result register,
//   where its result is valid. One column sum memory access pair (read plus
//   write) per cycle sets the rate. After reset and after each configuration
//   write the input is stalled while the row region is set up. The column sum
//   memory needs no clearing; each entry is written before it is read.
//   A stalled result holds the whole pipe, and the input is stalled with it.
module rgba_gray_box_downsample #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_FACTOR = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rgds_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rgds_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  rgds_pkg::pix_t                  in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output rgds_pkg::res_t                  out_data_o
);

  localparam int ADDR_W = $clog2(MAX_WIDTH / 2);

  rgds_pkg::cmd_t    cmd;
  rgds_pkg::stat_t   stat;
  logic [ADDR_W-1:0] cmd_addr;

  rgds_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_FACTOR(MAX_FACTOR)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .cmd_addr_o (cmd_addr)
  );

  rgds_dp #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_FACTOR(MAX_FACTOR)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cmd_addr_i (cmd_addr),
    .pix_i      (in_data_i),
    .stat_o     (stat),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

>>> rtl/rgds_ctrl.sv
// Controller: configuration registers, raster position counters and row-region FSM.
`include "rgba_gray_box_downsample_macros.svh"

module rgds_ctrl #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_FACTOR = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rgds_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [rgds_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  rgds_pkg::stat_t                   stat_i,
  output rgds_pkg::cmd_t                    cmd_o,
  output logic [$clog2(MAX_WIDTH/2)-1:0]    cmd_addr_o
);

  localparam int W_W    = $clog2(MAX_WIDTH + 1);
  localparam int CB_W   = W_W + 1;
  localparam int RB_W   = rgds_pkg::HEIGHT_W + 1;
  localparam int PH_W   = $clog2(MAX_FACTOR);
  localparam int ADDR_W = $clog2(MAX_WIDTH / 2);
  localparam int FW     = rgds_pkg::FACTOR_W;
  localparam int HW     = rgds_pkg::HEIGHT_W;

  // State codes
  localparam logic [1:0] ST_START    = 2'd0;
  localparam logic [1:0] ST_PASS     = 2'd1;
  localparam logic [1:0] ST_ROW_BOX  = 2'd2;
  localparam logic [1:0] ST_ROW_DROP = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [W_W-1:0]    width_q, width_d;
  logic [HW-1:0]     height_q, height_d;
  logic [FW-1:0]     factor_q, factor_d;
  logic              rgba_q, rgba_d;
  logic [W_W-1:0]    src_col_q, src_col_d;
  logic [HW-1:0]     src_row_q, src_row_d;
  logic [PH_W-1:0]   cph_q, cph_d;
  logic [PH_W-1:0]   rph_q, rph_d;
  logic [ADDR_W-1:0] out_col_q, out_col_d;
  logic [CB_W-1:0]   col_base_q, col_base_d;
  logic [RB_W-1:0]   row_base_q, row_base_d;

  logic            accept;
  logic            last_col, last_row;
  logic [FW-1:0]   fm1;
  logic            cph_last, rph_last;
  logic            col_fit, active;
  logic            row_end_box, row_last_box;
  logic [RB_W-1:0] rb_next;
  logic            next_row_fits;
  logic [1:0]      start_state;

  // Handshake
  assign in_stall_o = !stat_i.advance || (state_q == ST_START);
  assign accept     = in_valid_i && !in_stall_o;

  // Position decode
  assign last_col      = src_col_q == (width_q - W_W'(1));
  assign last_row      = src_row_q == (height_q - HW'(1));
  assign fm1           = factor_q - FW'(1);
  assign cph_last      = FW'(cph_q) == fm1;
  assign rph_last      = FW'(rph_q) == fm1;
  assign col_fit       = (col_base_q + CB_W'(factor_q)) <= CB_W'(width_q);
  assign active        = (state_q == ST_ROW_BOX) && col_fit;
  assign row_end_box   = (col_base_q + CB_W'({factor_q, 1'b0})) > CB_W'(width_q);
  assign row_last_box  = (row_base_q + RB_W'({factor_q, 1'b0})) > RB_W'(height_q);
  assign rb_next       = row_base_q + RB_W'(factor_q);
  assign next_row_fits = (rb_next + RB_W'(factor_q)) <= RB_W'(height_q);
  assign start_state   = (factor_q == FW'(1)) ? ST_PASS :
                         ((RB_W'(factor_q) <= RB_W'(height_q)) ? ST_ROW_BOX : ST_ROW_DROP);

  // Next-state and counter logic
  always_comb begin
    state_d    = state_q;
    width_d    = width_q;
    height_d   = height_q;
    factor_d   = factor_q;
    rgba_d     = rgba_q;
    src_col_d  = src_col_q;
    src_row_d  = src_row_q;
    cph_d      = cph_q;
    rph_d      = rph_q;
    out_col_d  = out_col_q;
    col_base_d = col_base_q;
    row_base_d = row_base_q;

    if (cfg_we_i) begin
      // Any write restarts the frame
      case (cfg_index_i)
        rgds_pkg::REG_SRC_WIDTH: begin
          if (cfg_data_i == '0) begin
            width_d = W_W'(1);
          end else if (32'(cfg_data_i) > 32'(MAX_WIDTH)) begin
            width_d = W_W'(MAX_WIDTH);
          end else begin
            width_d = W_W'(cfg_data_i);
          end
        end
        rgds_pkg::REG_SRC_HEIGHT: begin
          if (cfg_data_i == '0) begin
            height_d = HW'(1);
          end else if (32'(cfg_data_i) > 32'(rgds_pkg::HEIGHT_LIMIT)) begin
            height_d = HW'(rgds_pkg::HEIGHT_LIMIT);
          end else begin
            height_d = cfg_data_i;
          end
        end
        rgds_pkg::REG_DOWN_FACTOR: begin
          if (cfg_data_i[3:0] <= 4'd1) begin
            factor_d = FW'(1);
          end else if (32'(cfg_data_i[3:0]) > 32'(MAX_FACTOR)) begin
            factor_d = FW'(MAX_FACTOR);
          end else begin
            factor_d = FW'(cfg_data_i[3:0]);
          end
        end
        rgds_pkg::REG_PIXEL_FORMAT: begin
          rgba_d = cfg_data_i[0];
        end
        default: begin
        end
      endcase
      state_d    = ST_START;
      src_col_d  = '0;
      src_row_d  = '0;
      cph_d      = '0;
      rph_d      = '0;
      out_col_d  = '0;
      col_base_d = '0;
      row_base_d = '0;
    end else if (state_q == ST_START) begin
      state_d = start_state;
    end else if (accept) begin
      if (!last_col) begin
        src_col_d = src_col_q + W_W'(1);
        if (active) begin
          if (cph_last) begin
            cph_d      = '0;
            out_col_d  = out_col_q + ADDR_W'(1);
            col_base_d = col_base_q + CB_W'(factor_q);
          end else begin
            cph_d = cph_q + PH_W'(1);
          end
        end
      end else begin
        src_col_d  = '0;
        cph_d      = '0;
        out_col_d  = '0;
        col_base_d = '0;
        if (last_row) begin
          // Frame wrap
          src_row_d  = '0;
          rph_d      = '0;
          row_base_d = '0;
          state_d    = start_state;
        end else begin
          src_row_d = src_row_q + HW'(1);
          if (rph_last) begin
            rph_d      = '0;
            row_base_d = rb_next;
            if (state_q != ST_PASS) begin
              state_d = next_row_fits ? ST_ROW_BOX : ST_ROW_DROP;
            end
          end else begin
            rph_d = rph_q + PH_W'(1);
          end
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_START;
      width_q    <= W_W'(1);
      height_q   <= HW'(1);
      factor_q   <= FW'(1);
      rgba_q     <= 1'b0;
      src_col_q  <= '0;
      src_row_q  <= '0;
      cph_q      <= '0;
      rph_q      <= '0;
      out_col_q  <= '0;
      col_base_q <= '0;
      row_base_q <= '0;
    end else begin
      state_q    <= state_d;
      width_q    <= width_d;
      height_q   <= height_d;
      factor_q   <= factor_d;
      rgba_q     <= rgba_d;
      src_col_q  <= src_col_d;
      src_row_q  <= src_row_d;
      cph_q      <= cph_d;
      rph_q      <= rph_d;
      out_col_q  <= out_col_d;
      col_base_q <= col_base_d;
      row_base_q <= row_base_d;
    end
  end

  // Command to the datapath for the beat taken this cycle
  always_comb begin
    cmd_o.load      = accept;
    cmd_o.pass      = state_q == ST_PASS;
    cmd_o.rgba      = rgba_q;
    cmd_o.active    = active;
    cmd_o.col_first = cph_q == '0;
    cmd_o.col_last  = cph_last;
    cmd_o.row_first = rph_q == '0;
    cmd_o.factor    = factor_q;
    if (state_q == ST_PASS) begin
      cmd_o.emit      = 1'b1;
      cmd_o.row_end   = last_col;
      cmd_o.frame_end = last_col && last_row;
    end else begin
      cmd_o.emit      = active && cph_last && rph_last;
      cmd_o.row_end   = row_end_box;
      cmd_o.frame_end = row_end_box && rph_last && row_last_box;
    end
  end
  assign cmd_addr_o = out_col_q;

  `RGDS_ASSERT(a_cph_below_factor, FW'(cph_q) < factor_q, "box column phase out of range")
  `RGDS_ASSERT_IMP(a_frame_end_on_row_end, cmd_o.load && cmd_o.emit && cmd_o.frame_end, cmd_o.row_end, "frame end without row end")
  `RGDS_ASSERT_NEXT(a_frame_wrap, accept && last_col && last_row, src_col_q == '0 && src_row_q == '0, "counters did not wrap at frame end")

endmodule

>>> rtl/rgds_dp.sv
// Datapath: luma, horizontal box sums, column sum memory and box average pipeline.
`include "rgba_gray_box_downsample_macros.svh"

module rgds_dp #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_FACTOR = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rgds_pkg::cmd_t                 cmd_i,
  input  logic [$clog2(MAX_WIDTH/2)-1:0] cmd_addr_i,
  input  rgds_pkg::pix_t                 pix_i,
  output rgds_pkg::stat_t                stat_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output rgds_pkg::res_t                 out_data_o
);

  localparam int ADDR_W    = $clog2(MAX_WIDTH / 2);
  localparam int MEM_DEPTH = MAX_WIDTH / 2;
  localparam int SUM_W     = 8 + 2 * $clog2(MAX_FACTOR);
  localparam int RW        = rgds_pkg::RECIP_W;
  localparam int PROD_W    = SUM_W + RW;

  logic adv;

  logic                  s1_v_q;
  rgds_pkg::pix_t        pix1_q;
  rgds_pkg::cmd_t        cmd1_q;
  logic [ADDR_W-1:0]     addr1_q;
  logic [15:0]           luma_sum;
  logic [7:0]            gray1;

  logic                  s2_v_q;
  logic [7:0]            gray2_q;
  rgds_pkg::cmd_t        cmd2_q;
  logic [ADDR_W-1:0]     addr2_q;
  logic [SUM_W-1:0]      hsum_q;
  logic [SUM_W-1:0]      hsum_sum;
  logic [SUM_W-1:0]      colsum;

  logic [SUM_W-1:0]      mem [MEM_DEPTH];
  logic [SUM_W-1:0]      rd_q;
  logic                  rd_en;
  logic                  mem_we;

  logic                  s3_v_q;
  logic [SUM_W-1:0]      sum3_q;
  logic [RW-1:0]         recip3_q;
  logic                  re3_q;
  logic                  fe3_q;
  logic [PROD_W-1:0]     prod;

  logic                  out_v_q;
  rgds_pkg::res_t        out_q;

  // Whole pipe moves unless the result register is full and stalled
  assign adv            = !out_v_q || !out_stall_i;
  assign stat_o.advance = adv;

  // Stage 1: captured beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= cmd_i.load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && cmd_i.load) begin
      pix1_q  <= pix_i;
      cmd1_q  <= cmd_i;
      addr1_q <= cmd_addr_i;
    end
  end

  // Luma conversion
  assign luma_sum = rgds_pkg::LUMA_R * {8'd0, pix1_q.chan_red}
                  + rgds_pkg::LUMA_G * {8'd0, pix1_q.chan_green}
                  + rgds_pkg::LUMA_B * {8'd0, pix1_q.chan_blue};
  assign gray1    = cmd1_q.rgba ? luma_sum[15:8] : pix1_q.chan_red;

  // Fetch the column sum at the start of each box row segment, except in a box's first row
  assign rd_en = adv && s1_v_q && cmd1_q.active && cmd1_q.col_first && !cmd1_q.row_first;

  // Stage 2: gray value, horizontal sum and column sum update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (adv) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_v_q) begin
      gray2_q <= gray1;
      cmd2_q  <= cmd1_q;
      addr2_q <= addr1_q;
    end
  end

  assign hsum_sum = (cmd2_q.col_first ? '0 : hsum_q) + SUM_W'(gray2_q);
  assign colsum   = (cmd2_q.row_first ? '0 : rd_q) + hsum_sum;
  assign mem_we   = adv && s2_v_q && cmd2_q.active && cmd2_q.col_last;

  always_ff @(posedge clk_i) begin
    if (adv && s2_v_q && cmd2_q.active) begin
      hsum_q <= hsum_sum;
    end
  end

  // Column sum memory, write-through on a same-address read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[addr2_q] <= colsum;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= (mem_we && (addr2_q == addr1_q)) ? colsum : mem[addr1_q];
    end
  end

  // Stage 3: box sum and its reciprocal
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (adv) begin
      s3_v_q <= s2_v_q && cmd2_q.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s2_v_q && cmd2_q.emit) begin
      sum3_q   <= cmd2_q.pass ? SUM_W'(gray2_q) : colsum;
      recip3_q <= rgds_pkg::recip_of(cmd2_q.factor);
      re3_q    <= cmd2_q.row_end;
      fe3_q    <= cmd2_q.frame_end;
    end
  end

  assign prod = PROD_W'(sum3_q) * PROD_W'(recip3_q);

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s3_v_q) begin
      out_q.out_gray  <= prod[rgds_pkg::RECIP_SHIFT +: 8];
      out_q.row_end   <= re3_q;
      out_q.frame_end <= fe3_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  `RGDS_ASSERT_IMP(a_emit_writes_column, adv && s2_v_q && cmd2_q.emit && !cmd2_q.pass, mem_we, "box result without column sum write")
  `RGDS_ASSERT_NEXT(a_rd_bypass, rd_en && mem_we && (addr1_q == addr2_q), rd_q == $past(colsum), "column sum bypass lost")
  `RGDS_ASSERT_NEXT(a_stall_freezes_pipe, out_v_q && out_stall_i, $stable(s1_v_q) && $stable(s2_v_q) && $stable(s3_v_q), "pipe moved while result stalled")

endmodule
